@@ hdl/csaz_pkg.sv @@
// Package for the current-sense auto-zero and gate chopper unit.
// Holds the shared constants, command codes and register indexes.
// No dependencies.
`default_nettype none

package csaz_pkg;

   // Default ADC sample width.
   localparam int ADC_BITS_DEFAULT = 12;

   // Widths of the configuration registers.
   localparam int CAL_SAMPLES_W = 16;
   localparam int DC_LIMIT_W    = 12;
   localparam int TIMEOUT_W     = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;

   // Number of sampled channels per set.
   localparam int NUM_CHANNELS = 6;

   // Offset tracking filter: offset = (raw + 11 * offset) / 12.
   // The divide by twelve is done as a shift by two and a divide by three.
   localparam int OFFSET_START = 2000;
   localparam int CAL_WEIGHT   = 11;
   localparam int CAL_SHIFT    = 2;
   localparam int CAL_DIV_ODD  = 3;

   // Register reset values.
   localparam logic [CAL_SAMPLES_W-1:0] CAL_SAMPLES_RESET = 16'd1000;
   localparam logic [DC_LIMIT_W-1:0]    DC_LIMIT_RESET    = 12'd1500;
   localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RESET     = 16'd20;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAL_SAMPLES = 2'd0,
      CSR_DC_LIMIT    = 2'd1,
      CSR_TIMEOUT     = 2'd2
   } csr_index_type;

   // Transaction commands.
   typedef enum logic [0:0] {
      CMD_PROCESS = 1'b0,
      CMD_RESTART = 1'b1
   } command_type;

   // Channel order in the offset store.
   localparam int CH_LEFT_A     = 0;
   localparam int CH_LEFT_B     = 1;
   localparam int CH_LEFT_DC    = 2;
   localparam int CH_RIGHT_C    = 3;
   localparam int CH_RIGHT_B    = 4;
   localparam int CH_RIGHT_DC   = 5;

endpackage

`default_nettype wire

@@ hdl/current_sense_autozero_chopper_unit.sv @@
// Top level of the current-sense auto-zero and gate chopper unit.
// Depends on csaz_pkg for constants, register indexes and command codes.
// Contains the input register, the single-pass datapath and the result register.
`default_nettype none

// One transaction carries one set of six current-sense ADC samples for two
// motors and yields one result transaction. The block takes a new sample set
// every clock cycle while the result side is not stalled; each set is held in
// the input register and then in the result register. After reset or a restart
// command the first cal_samples sets update the channel offsets and report
// calibrating with zero currents and both gates off; later sets report
// offset-minus-raw currents, and a motor's gate is on only while its DC current
// magnitude, the timeout count and the drive enable are all within bounds.
// Configuration writes take effect at once and are meant to be made while no
// transaction is in flight.
module current_sense_autozero_chopper_unit #(
   parameter int ADC_BITS = csaz_pkg::ADC_BITS_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,

   // Configuration write port.
   input  wire                                    csr_write,
   input  wire  [csaz_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [csaz_pkg::CSR_DATA_W-1:0]        csr_wdata,

   // Sample set channel.
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire                                    req_command,
   input  wire  [ADC_BITS-1:0]                    req_left_phase_a_raw,
   input  wire  [ADC_BITS-1:0]                    req_left_phase_b_raw,
   input  wire  [ADC_BITS-1:0]                    req_left_dc_raw,
   input  wire  [ADC_BITS-1:0]                    req_right_first_raw,
   input  wire  [ADC_BITS-1:0]                    req_right_second_raw,
   input  wire  [ADC_BITS-1:0]                    req_right_dc_raw,
   input  wire  [csaz_pkg::TIMEOUT_W-1:0]         req_timeout_count,
   input  wire                                    req_drive_enable,

   // Result channel.
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic                                   rsp_calibrating,
   output logic signed [ADC_BITS:0]               rsp_left_current_a,
   output logic signed [ADC_BITS:0]               rsp_left_current_b,
   output logic signed [ADC_BITS:0]               rsp_left_current_dc,
   output logic signed [ADC_BITS:0]               rsp_right_current_b,
   output logic signed [ADC_BITS:0]               rsp_right_current_c,
   output logic signed [ADC_BITS:0]               rsp_right_current_dc,
   output logic                                   rsp_left_gate_on,
   output logic                                   rsp_right_gate_on
);

   localparam int NCH = csaz_pkg::NUM_CHANNELS;

   // Filter sum raw + 11 * offset stays below 12 * 2^ADC_BITS.
   localparam int SUM_W  = ADC_BITS + 4;
   // Sum after the shift by two, the operand of the divide by three.
   localparam int DIV_W  = SUM_W - csaz_pkg::CAL_SHIFT;
   // Reciprocal of three, exact for every DIV_W-bit operand.
   localparam int RECIP_SH = DIV_W + 1;
   localparam int RECIP_W  = DIV_W + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((2 ** RECIP_SH) + csaz_pkg::CAL_DIV_ODD - 1) / csaz_pkg::CAL_DIV_ODD);
   localparam int PROD_W = DIV_W + RECIP_W;
   // Width for the DC current magnitude compare.
   localparam int CMP_W  = (ADC_BITS + 1 > csaz_pkg::DC_LIMIT_W) ?
                           ADC_BITS + 1 : csaz_pkg::DC_LIMIT_W;
   localparam logic [ADC_BITS-1:0] OFFSET_INIT = ADC_BITS'(csaz_pkg::OFFSET_START);

   // Configuration registers.
   logic [csaz_pkg::CAL_SAMPLES_W-1:0] cal_samples_ff;
   logic [csaz_pkg::DC_LIMIT_W-1:0]    dc_limit_ff;
   logic [csaz_pkg::TIMEOUT_W-1:0]     timeout_limit_ff;

   // Input register.
   logic                               in_valid_ff;
   logic                               in_command_ff;
   logic [ADC_BITS-1:0]                in_raw_ff [NCH];
   logic [csaz_pkg::TIMEOUT_W-1:0]     in_timeout_ff;
   logic                               in_enable_ff;

   // Calibration state.
   logic [csaz_pkg::CAL_SAMPLES_W-1:0] cal_counter_ff;
   logic [csaz_pkg::CAL_SAMPLES_W-1:0] cal_counter_in;
   logic [ADC_BITS-1:0]                offset_ff [NCH];
   logic [ADC_BITS-1:0]                offset_in [NCH];

   // Result register.
   logic                               out_valid_ff;
   logic                               out_cal_ff;
   logic                               out_cal_in;
   logic signed [ADC_BITS:0]           out_cur_ff [NCH];
   logic signed [ADC_BITS:0]           out_cur_in [NCH];
   logic                               out_left_gate_ff;
   logic                               out_left_gate_in;
   logic                               out_right_gate_ff;
   logic                               out_right_gate_in;

   // Datapath intermediates.
   logic [SUM_W-1:0]                   filt_sum [NCH];
   logic [DIV_W-1:0]                   filt_quarter [NCH];
   logic [PROD_W-1:0]                  filt_prod [NCH];
   logic [ADC_BITS-1:0]                filt_offset [NCH];
   logic signed [ADC_BITS:0]           diff [NCH];
   logic [ADC_BITS:0]                  left_mag;
   logic [ADC_BITS:0]                  right_mag;
   logic                               common_ok;
   logic                               in_calibration;
   logic                               advance;

   // The input register moves on when the result register is empty or drained.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   // Configuration writes; indexes beyond the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_samples_ff   <= csaz_pkg::CAL_SAMPLES_RESET;
         dc_limit_ff      <= csaz_pkg::DC_LIMIT_RESET;
         timeout_limit_ff <= csaz_pkg::TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csaz_pkg::csr_index_type'(csr_index))
            csaz_pkg::CSR_CAL_SAMPLES: begin
               cal_samples_ff <= csr_wdata[csaz_pkg::CAL_SAMPLES_W-1:0];
            end
            csaz_pkg::CSR_DC_LIMIT: begin
               dc_limit_ff <= csr_wdata[csaz_pkg::DC_LIMIT_W-1:0];
            end
            csaz_pkg::CSR_TIMEOUT: begin
               timeout_limit_ff <= csr_wdata[csaz_pkg::TIMEOUT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input register valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // Input register payload, loaded with each accepted transaction.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_command_ff                    <= req_command;
         in_raw_ff[csaz_pkg::CH_LEFT_A]   <= req_left_phase_a_raw;
         in_raw_ff[csaz_pkg::CH_LEFT_B]   <= req_left_phase_b_raw;
         in_raw_ff[csaz_pkg::CH_LEFT_DC]  <= req_left_dc_raw;
         in_raw_ff[csaz_pkg::CH_RIGHT_C]  <= req_right_first_raw;
         in_raw_ff[csaz_pkg::CH_RIGHT_B]  <= req_right_second_raw;
         in_raw_ff[csaz_pkg::CH_RIGHT_DC] <= req_right_dc_raw;
         in_timeout_ff                    <= req_timeout_count;
         in_enable_ff                     <= req_drive_enable;
      end
   end

   // Offset filter per channel: (raw + 11 * offset) >> 2, then divide by three
   // through a reciprocal multiply.
   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         filt_sum[i] = SUM_W'(in_raw_ff[i])
                     + SUM_W'(offset_ff[i]) * SUM_W'(csaz_pkg::CAL_WEIGHT);
         filt_quarter[i] = filt_sum[i][SUM_W-1:csaz_pkg::CAL_SHIFT];
         filt_prod[i]    = PROD_W'(filt_quarter[i]) * PROD_W'(RECIP);
         filt_offset[i]  = filt_prod[i][RECIP_SH +: ADC_BITS];
         diff[i] = $signed({1'b0, offset_ff[i]}) - $signed({1'b0, in_raw_ff[i]});
      end
   end

   // DC current magnitudes and the shared gate conditions.
   always_comb begin
      left_mag  = diff[csaz_pkg::CH_LEFT_DC][ADC_BITS] ?
                  (ADC_BITS+1)'(-diff[csaz_pkg::CH_LEFT_DC]) :
                  (ADC_BITS+1)'(diff[csaz_pkg::CH_LEFT_DC]);
      right_mag = diff[csaz_pkg::CH_RIGHT_DC][ADC_BITS] ?
                  (ADC_BITS+1)'(-diff[csaz_pkg::CH_RIGHT_DC]) :
                  (ADC_BITS+1)'(diff[csaz_pkg::CH_RIGHT_DC]);
      common_ok = (in_timeout_ff <= timeout_limit_ff) && in_enable_ff;
   end

   // Next state and next result for the transaction in the input register.
   always_comb begin
      in_calibration    = cal_counter_ff < cal_samples_ff;
      cal_counter_in    = cal_counter_ff;
      out_cal_in        = 1'b1;
      out_left_gate_in  = 1'b0;
      out_right_gate_in = 1'b0;
      for (int i = 0; i < NCH; i++) begin
         offset_in[i]  = offset_ff[i];
         out_cur_in[i] = '0;
      end
      if (csaz_pkg::command_type'(in_command_ff) == csaz_pkg::CMD_RESTART) begin
         // Restart: clear the count and reload the start offsets.
         cal_counter_in = '0;
         for (int i = 0; i < NCH; i++) begin
            offset_in[i] = OFFSET_INIT;
         end
      end else if (in_calibration) begin
         // Calibration set: track the offsets, report zero currents.
         cal_counter_in = cal_counter_ff + 1'b1;
         for (int i = 0; i < NCH; i++) begin
            offset_in[i] = filt_offset[i];
         end
      end else begin
         // Measurement set: currents against the settled offsets.
         out_cal_in = 1'b0;
         for (int i = 0; i < NCH; i++) begin
            out_cur_in[i] = diff[i];
         end
         out_left_gate_in  = common_ok && (CMP_W'(left_mag) <= CMP_W'(dc_limit_ff));
         out_right_gate_in = common_ok && (CMP_W'(right_mag) <= CMP_W'(dc_limit_ff));
      end
   end

   // Calibration state advances as each transaction leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_counter_ff <= '0;
         for (int i = 0; i < NCH; i++) begin
            offset_ff[i] <= OFFSET_INIT;
         end
      end else if (in_valid_ff && advance) begin
         cal_counter_ff <= cal_counter_in;
         for (int i = 0; i < NCH; i++) begin
            offset_ff[i] <= offset_in[i];
         end
      end
   end

   // Result register valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         out_cal_ff        <= out_cal_in;
         out_left_gate_ff  <= out_left_gate_in;
         out_right_gate_ff <= out_right_gate_in;
         for (int i = 0; i < NCH; i++) begin
            out_cur_ff[i] <= out_cur_in[i];
         end
      end
   end

   // Result ports.
   assign rsp_valid            = out_valid_ff;
   assign rsp_calibrating      = out_cal_ff;
   assign rsp_left_current_a   = out_cur_ff[csaz_pkg::CH_LEFT_A];
   assign rsp_left_current_b   = out_cur_ff[csaz_pkg::CH_LEFT_B];
   assign rsp_left_current_dc  = out_cur_ff[csaz_pkg::CH_LEFT_DC];
   assign rsp_right_current_c  = out_cur_ff[csaz_pkg::CH_RIGHT_C];
   assign rsp_right_current_b  = out_cur_ff[csaz_pkg::CH_RIGHT_B];
   assign rsp_right_current_dc = out_cur_ff[csaz_pkg::CH_RIGHT_DC];
   assign rsp_left_gate_on     = out_left_gate_ff;
   assign rsp_right_gate_on    = out_right_gate_ff;

   // A calibrating result carries zero left A and DC currents and both gates off.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_calibrating) |->
         (!rsp_left_gate_on && !rsp_right_gate_on && rsp_left_current_dc == '0
          && rsp_right_current_dc == '0 && rsp_left_current_a == '0))
      else $error("calibrating result with nonzero current or gate on");

   // A restart transaction leaves the calibration count at zero.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance
       && csaz_pkg::command_type'(in_command_ff) == csaz_pkg::CMD_RESTART) |=>
         (cal_counter_ff == '0 && out_valid_ff && out_cal_ff))
      else $error("restart did not clear the calibration count");

   // The count and the DC offsets only change when a transaction passes to the result register.
   assert property (@(posedge clock) disable iff (reset)
      !(in_valid_ff && advance) |=> ($stable(cal_counter_ff)
         && $stable(offset_ff[csaz_pkg::CH_LEFT_DC])
         && $stable(offset_ff[csaz_pkg::CH_RIGHT_DC])))
      else $error("calibration state changed without a transaction");

   // The input side is only held off while the input register is full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

@@ bench/current_sense_autozero_chopper_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for current_sense_autozero_chopper_unit.
// Uses csaz_pkg for widths, command codes and register indexes; predicts every
// result from its own offset-calibration and gate model and checks it field by field.

module current_sense_autozero_chopper_unit_test;

   localparam int ADC_W       = csaz_pkg::ADC_BITS_DEFAULT;
   localparam int CUR_W       = ADC_W + 1;
   localparam int TMO_W       = csaz_pkg::TIMEOUT_W;
   localparam int CSR_W       = csaz_pkg::CSR_DATA_W;
   localparam int NCH         = csaz_pkg::NUM_CHANNELS;
   localparam int ADC_MAX     = (1 << ADC_W) - 1;
   localparam int TMO_MAX     = (1 << TMO_W) - 1;
   localparam int AVG_WEIGHT  = 11;
   localparam int AVG_DIVISOR = 12;
   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 9;
   localparam int DRAIN_CYCLES = 6;
   localparam int LONG_HOLD   = 200;
   localparam int RANDOM_ITEMS = 2000;
   localparam int CALM_ITEMS  = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      csaz_pkg::command_type command;
      logic [ADC_W-1:0]   left_a;
      logic [ADC_W-1:0]   left_b;
      logic [ADC_W-1:0]   left_dc;
      logic [ADC_W-1:0]   right_first;
      logic [ADC_W-1:0]   right_second;
      logic [ADC_W-1:0]   right_dc;
      logic [TMO_W-1:0]   timeout_count;
      logic               drive_enable;
   } sample_set_type;

   typedef struct packed {
      logic               calibrating;
      logic signed [CUR_W-1:0] left_a;
      logic signed [CUR_W-1:0] left_b;
      logic signed [CUR_W-1:0] left_dc;
      logic signed [CUR_W-1:0] right_b;
      logic signed [CUR_W-1:0] right_c;
      logic signed [CUR_W-1:0] right_dc;
      logic               left_gate;
      logic               right_gate;
   } reading_type;

   // Clock, reset and block inputs, all known from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [csaz_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_command = 1'b0;
   logic [ADC_W-1:0] req_left_phase_a_raw = '0;
   logic [ADC_W-1:0] req_left_phase_b_raw = '0;
   logic [ADC_W-1:0] req_left_dc_raw = '0;
   logic [ADC_W-1:0] req_right_first_raw = '0;
   logic [ADC_W-1:0] req_right_second_raw = '0;
   logic [ADC_W-1:0] req_right_dc_raw = '0;
   logic [TMO_W-1:0] req_timeout_count = '0;
   logic req_drive_enable = 1'b0;
   logic rsp_stall = 1'b0;

   wire req_stall;
   wire rsp_valid;
   wire rsp_calibrating;
   wire signed [CUR_W-1:0] rsp_left_current_a;
   wire signed [CUR_W-1:0] rsp_left_current_b;
   wire signed [CUR_W-1:0] rsp_left_current_dc;
   wire signed [CUR_W-1:0] rsp_right_current_b;
   wire signed [CUR_W-1:0] rsp_right_current_c;
   wire signed [CUR_W-1:0] rsp_right_current_dc;
   wire rsp_left_gate_on;
   wire rsp_right_gate_on;

   // Shared bench state.
   sample_set_type pending_sets[$];
   reading_type expected_readings[$];
   sample_set_type offered_set;
   int error_count = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   int long_hold_left = 0;
   bit long_hold_done = 1'b0;
   bit want_long_hold = 1'b0;
   bit calm = 1'b0;

   // Model of the calibration state and the register copies.
   int model_cal_samples;
   int model_dc_limit;
   int model_timeout_limit;
   int model_cal_count;
   int model_offset [NCH];

   current_sense_autozero_chopper_unit dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_left_phase_a_raw(req_left_phase_a_raw),
      .req_left_phase_b_raw(req_left_phase_b_raw),
      .req_left_dc_raw(req_left_dc_raw),
      .req_right_first_raw(req_right_first_raw),
      .req_right_second_raw(req_right_second_raw),
      .req_right_dc_raw(req_right_dc_raw),
      .req_timeout_count(req_timeout_count),
      .req_drive_enable(req_drive_enable),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_calibrating(rsp_calibrating),
      .rsp_left_current_a(rsp_left_current_a),
      .rsp_left_current_b(rsp_left_current_b),
      .rsp_left_current_dc(rsp_left_current_dc),
      .rsp_right_current_b(rsp_right_current_b),
      .rsp_right_current_c(rsp_right_current_c),
      .rsp_right_current_dc(rsp_right_current_dc),
      .rsp_left_gate_on(rsp_left_gate_on),
      .rsp_right_gate_on(rsp_right_gate_on)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Restart calibration: counter cleared, every offset back to its start value.
   function automatic void restart_offsets();
      model_cal_count = 0;
      for (int i = 0; i < NCH; i++) begin
         model_offset[i] = csaz_pkg::OFFSET_START;
      end
   endfunction

   // A gate is on only while the DC current, the timeout and the enable allow it.
   function automatic logic gate_allowed(int dc, int tmo, logic en);
      int mag;
      mag = (dc < 0) ? -dc : dc;
      return (mag <= model_dc_limit) && (tmo <= model_timeout_limit) && en;
   endfunction

   // Advances the calibration model by one sample set and returns its reading.
   function automatic reading_type predict_reading(sample_set_type s);
      reading_type r;
      int raw [NCH];
      int diff [NCH];
      r = '0;
      raw[csaz_pkg::CH_LEFT_A]   = s.left_a;
      raw[csaz_pkg::CH_LEFT_B]   = s.left_b;
      raw[csaz_pkg::CH_LEFT_DC]  = s.left_dc;
      raw[csaz_pkg::CH_RIGHT_C]  = s.right_first;
      raw[csaz_pkg::CH_RIGHT_B]  = s.right_second;
      raw[csaz_pkg::CH_RIGHT_DC] = s.right_dc;
      if (s.command == csaz_pkg::CMD_RESTART) begin
         restart_offsets();
         r.calibrating = 1'b1;
         return r;
      end
      // Calibration sets move the offsets and report nothing else.
      if (model_cal_count < model_cal_samples) begin
         model_cal_count++;
         for (int i = 0; i < NCH; i++) begin
            model_offset[i] = (raw[i] + AVG_WEIGHT * model_offset[i]) / AVG_DIVISOR;
         end
         r.calibrating = 1'b1;
         return r;
      end
      for (int i = 0; i < NCH; i++) begin
         diff[i] = model_offset[i] - raw[i];
      end
      r.left_a     = CUR_W'(diff[csaz_pkg::CH_LEFT_A]);
      r.left_b     = CUR_W'(diff[csaz_pkg::CH_LEFT_B]);
      r.left_dc    = CUR_W'(diff[csaz_pkg::CH_LEFT_DC]);
      r.right_b    = CUR_W'(diff[csaz_pkg::CH_RIGHT_B]);
      r.right_c    = CUR_W'(diff[csaz_pkg::CH_RIGHT_C]);
      r.right_dc   = CUR_W'(diff[csaz_pkg::CH_RIGHT_DC]);
      r.left_gate  = gate_allowed(diff[csaz_pkg::CH_LEFT_DC], s.timeout_count,
                                  s.drive_enable);
      r.right_gate = gate_allowed(diff[csaz_pkg::CH_RIGHT_DC], s.timeout_count,
                                  s.drive_enable);
      return r;
   endfunction

   // A value around a center, clamped to 0..top.
   function automatic int near_value(int center, int spread, int top);
      int draw;
      int v;
      draw = $urandom_range(0, 2 * spread);
      v = center + draw - spread;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v;
   endfunction

   // Mostly samples close to the phase baseline, some anywhere in range.
   function automatic logic [ADC_W-1:0] raw_sample(int center, int spread);
      if ($urandom_range(0, 4) == 0) return ADC_W'($urandom_range(0, ADC_MAX));
      return ADC_W'(near_value(center, spread, ADC_MAX));
   endfunction

   function automatic sample_set_type flat_set(csaz_pkg::command_type cmd, int raw,
                                               int tmo, logic en);
      sample_set_type s;
      s.command       = cmd;
      s.left_a        = ADC_W'(raw);
      s.left_b        = ADC_W'(raw);
      s.left_dc       = ADC_W'(raw);
      s.right_first   = ADC_W'(raw);
      s.right_second  = ADC_W'(raw);
      s.right_dc      = ADC_W'(raw);
      s.timeout_count = TMO_W'(tmo);
      s.drive_enable  = en;
      return s;
   endfunction

   function automatic sample_set_type random_set(int baseline, int dc_spread, int tmo_limit);
      sample_set_type s;
      int tmo_top;
      if ($urandom_range(0, 59) == 0) s.command = csaz_pkg::CMD_RESTART;
      else s.command = csaz_pkg::CMD_PROCESS;
      s.left_a       = raw_sample(baseline, 400);
      s.left_b       = raw_sample(baseline, 400);
      s.left_dc      = raw_sample(baseline, dc_spread);
      s.right_first  = raw_sample(baseline, 400);
      s.right_second = raw_sample(baseline, 400);
      s.right_dc     = raw_sample(baseline, dc_spread);
      tmo_top = (tmo_limit + 2 > TMO_MAX) ? TMO_MAX : tmo_limit + 2;
      case ($urandom_range(0, 3))
         0, 1: s.timeout_count = TMO_W'($urandom_range(0, tmo_top));
         2: s.timeout_count = TMO_W'(near_value(tmo_limit, 1, TMO_MAX));
         default: s.timeout_count = TMO_W'($urandom_range(0, TMO_MAX));
      endcase
      s.drive_enable = ($urandom_range(0, 9) != 0);
      return s;
   endfunction

   // Writes all three registers on consecutive edges; the block is idle here.
   task automatic apply_settings(int cal, int lim, int tmo);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= csaz_pkg::CSR_CAL_SAMPLES;
      csr_wdata <= CSR_W'(cal);
      @(posedge clock);
      csr_index <= csaz_pkg::CSR_DC_LIMIT;
      csr_wdata <= CSR_W'(lim);
      @(posedge clock);
      csr_index <= csaz_pkg::CSR_TIMEOUT;
      csr_wdata <= CSR_W'(tmo);
      @(posedge clock);
      csr_write <= 1'b0;
      model_cal_samples   = cal;
      model_dc_limit      = lim;
      model_timeout_limit = tmo;
   endtask

   // Waits until every queued set is accepted and every reading has come back.
   task automatic wait_drained();
      while (pending_sets.size() != 0 || req_valid || expected_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(string field, logic signed [15:0] want,
                              logic signed [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Sender: offers queued sample sets, with random gaps between transactions.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_readings.push_back(predict_reading(offered_set));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               gap_left = $urandom_range(0, 7);
               req_valid <= 1'b0;
            end else if (pending_sets.size() != 0) begin
               offered_set = pending_sets.pop_front();
               req_valid <= 1'b1;
               req_command <= offered_set.command;
               req_left_phase_a_raw <= offered_set.left_a;
               req_left_phase_b_raw <= offered_set.left_b;
               req_left_dc_raw <= offered_set.left_dc;
               req_right_first_raw <= offered_set.right_first;
               req_right_second_raw <= offered_set.right_second;
               req_right_dc_raw <= offered_set.right_dc;
               req_timeout_count <= offered_set.timeout_count;
               req_drive_enable <= offered_set.drive_enable;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: one long hold on request, otherwise short random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_stall <= 1'b1;
      end else if (want_long_hold && !long_hold_done) begin
         long_hold_done = 1'b1;
         long_hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: each accepted reading is checked against the oldest prediction.
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: reading with no sample set outstanding", $time);
            error_count++;
         end else begin
            want = expected_readings.pop_front();
            check_field("calibrating", want.calibrating, rsp_calibrating);
            check_field("left_current_a", $signed(want.left_a), rsp_left_current_a);
            check_field("left_current_b", $signed(want.left_b), rsp_left_current_b);
            check_field("left_current_dc", $signed(want.left_dc), rsp_left_current_dc);
            check_field("right_current_b", $signed(want.right_b), rsp_right_current_b);
            check_field("right_current_c", $signed(want.right_c), rsp_right_current_c);
            check_field("right_current_dc", $signed(want.right_dc), rsp_right_current_dc);
            check_field("left_gate_on", want.left_gate, rsp_left_gate_on);
            check_field("right_gate_on", want.right_gate, rsp_right_gate_on);
         end
      end
   end

   // Watchdog on the total run length.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stimulus: directed sets first, then random phases under varied settings.
   initial begin : stimulus
      sample_set_type s;
      int queued;
      int phase_index;
      int phase_len;
      int baseline;
      int cal;
      int lim;
      int tmo;
      int dc_spread;
      model_cal_samples   = csaz_pkg::CAL_SAMPLES_RESET;
      model_dc_limit      = csaz_pkg::DC_LIMIT_RESET;
      model_timeout_limit = csaz_pkg::TIMEOUT_RESET;
      restart_offsets();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: extreme samples during calibration.
      pending_sets.push_back(flat_set(csaz_pkg::CMD_PROCESS, 0, 0, 1'b1));
      pending_sets.push_back(flat_set(csaz_pkg::CMD_PROCESS, ADC_MAX, TMO_MAX, 1'b1));
      s = flat_set(csaz_pkg::CMD_PROCESS, 1, 5, 1'b0);
      s.left_b = ADC_W'(2); s.left_dc = ADC_W'(3); s.right_first = ADC_W'(4);
      s.right_second = ADC_W'(5); s.right_dc = ADC_W'(6);
      pending_sets.push_back(s);
      wait_drained();

      // No calibration: restart, then measure against the start offsets and
      // probe the gate limits from both sides.
      apply_settings(0, 100, 10);
      pending_sets.push_back(flat_set(csaz_pkg::CMD_RESTART, ADC_MAX, 0, 1'b1));
      pending_sets.push_back(flat_set(csaz_pkg::CMD_PROCESS, csaz_pkg::OFFSET_START,
                                      10, 1'b1));
      s = flat_set(csaz_pkg::CMD_PROCESS, csaz_pkg::OFFSET_START, 10, 1'b1);
      s.left_dc = ADC_W'(csaz_pkg::OFFSET_START - 100);
      s.right_dc = ADC_W'(csaz_pkg::OFFSET_START + 100);
      pending_sets.push_back(s);
      s.left_dc = ADC_W'(csaz_pkg::OFFSET_START - 101);
      s.right_dc = ADC_W'(csaz_pkg::OFFSET_START + 101);
      pending_sets.push_back(s);
      s.left_dc = ADC_W'(csaz_pkg::OFFSET_START);
      pending_sets.push_back(s);
      pending_sets.push_back(flat_set(csaz_pkg::CMD_PROCESS, csaz_pkg::OFFSET_START,
                                      11, 1'b1));
      pending_sets.push_back(flat_set(csaz_pkg::CMD_PROCESS, csaz_pkg::OFFSET_START,
                                      10, 1'b0));
      pending_sets.push_back(flat_set(csaz_pkg::CMD_PROCESS, 0, 0, 1'b1));
      pending_sets.push_back(flat_set(csaz_pkg::CMD_PROCESS, ADC_MAX, TMO_MAX, 1'b1));
      wait_drained();

      // Two calibration sets, the second being the last one, then widest limits.
      apply_settings(2, ADC_MAX, TMO_MAX);
      pending_sets.push_back(flat_set(csaz_pkg::CMD_RESTART, 0, 0, 1'b1));
      pending_sets.push_back(flat_set(csaz_pkg::CMD_PROCESS, 1000, 0, 1'b1));
      pending_sets.push_back(flat_set(csaz_pkg::CMD_PROCESS, 1000, 0, 1'b1));
      pending_sets.push_back(flat_set(csaz_pkg::CMD_PROCESS, 0, TMO_MAX, 1'b1));
      pending_sets.push_back(flat_set(csaz_pkg::CMD_PROCESS, ADC_MAX, 0, 1'b1));
      s = flat_set(csaz_pkg::CMD_PROCESS, 1, 7, 1'b1);
      s.left_b = ADC_W'(2); s.left_dc = ADC_W'(3); s.right_first = ADC_W'(4);
      s.right_second = ADC_W'(5); s.right_dc = ADC_W'(6);
      pending_sets.push_back(s);
      wait_drained();

      // Random phases, each under its own settings.
      queued = 0;
      phase_index = 0;
      while (queued < RANDOM_ITEMS - CALM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: cal = 0;
            1: cal = 1;
            2: cal = TMO_MAX;
            default: cal = $urandom_range(2, 30);
         endcase
         case ($urandom_range(0, 3))
            0: lim = 0;
            1: lim = ADC_MAX;
            2: lim = $urandom_range(0, ADC_MAX);
            default: lim = $urandom_range(20, 600);
         endcase
         case ($urandom_range(0, 3))
            0: tmo = 0;
            1: tmo = TMO_MAX;
            2: tmo = $urandom_range(0, TMO_MAX);
            default: tmo = $urandom_range(0, 200);
         endcase
         apply_settings(cal, lim, tmo);
         baseline = $urandom_range(1200, 2800);
         dc_spread = lim + lim / 4 + 10;
         if (dc_spread > ADC_MAX) dc_spread = ADC_MAX;
         phase_len = $urandom_range(80, 200);
         for (int i = 0; i < phase_len; i++) begin
            pending_sets.push_back(random_set(baseline, dc_spread, tmo));
         end
         queued += phase_len;
         // Hold the receiver off while this phase is still being offered.
         if (phase_index == 2) want_long_hold = 1'b1;
         phase_index++;
         wait_drained();
      end

      // Closing stretch at full rate on both sides.
      calm = 1'b1;
      lim = $urandom_range(50, 600);
      tmo = $urandom_range(5, 100);
      apply_settings($urandom_range(1, 20), lim, tmo);
      baseline = $urandom_range(1200, 2800);
      for (int i = 0; i < CALM_ITEMS; i++) begin
         pending_sets.push_back(random_set(baseline, lim + lim / 4 + 10, tmo));
      end
      wait_drained();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
